// ----- sv/rwct_pkg.sv -----
`timescale 1ns / 1ps

package rwct_pkg;

    // Field widths fixed by the interface.
    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int SIZE_W    = 11;
    localparam int TEXEL_W   = 10;
    localparam int DIST_W    = 24;
    localparam int DIR_W     = 16;
    localparam int POS_W     = 32;
    localparam int STEP_W    = SIZE_W + 16;
    localparam int CFG_IDX_W = 4;

    localparam int SCREEN_ROWS_DEFAULT = 512;

    localparam logic [DIST_W-1:0] MIN_DIST  = 24'd7;
    localparam logic [DIST_W-1:0] SLICE_MAX = 24'hFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;

    // Input item kinds.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ROW  = 1'b1;

    // Texture identifiers.
    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_EAST  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NORTH_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORTH_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_HEIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEST_WIDTH   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEST_HEIGHT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EAST_WIDTH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EAST_HEIGHT  = 4'd7;

    // Divider operand selection.
    localparam logic DIV_SEL_HEIGHT = 1'b0;
    localparam logic DIV_SEL_STEP   = 1'b1;

    typedef struct packed {
        logic capture_ray;
        logic emit_row;
        logic div_start;
        logic div_sel;
        logic save_h;
        logic save_step;
        logic commit;
    } rwct_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rows_pending;
    } rwct_status_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        begin
            if (v < SIZE_MIN)
            begin
                r = SIZE_MIN;
            end
            else if (v > SIZE_MAX)
            begin
                r = SIZE_MAX;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(
        input logic [1:0]        tid,
        input logic [SIZE_W-1:0] north,
        input logic [SIZE_W-1:0] south,
        input logic [SIZE_W-1:0] west,
        input logic [SIZE_W-1:0] east
    );
        logic [SIZE_W-1:0] r;
        begin
            case (tid)
                TEX_NORTH: r = north;
                TEX_SOUTH: r = south;
                TEX_WEST:  r = west;
                default:   r = east;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/rwct_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module rwct_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- sv/rwct_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer for ray loads and row ticks; owns the handshakes.
module rwct_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  mode,
    input  logic                  out_ready,
    input  rwct_pkg::rwct_status_t status,
    output logic                  in_ready,
    output logic                  out_valid,
    output rwct_pkg::rwct_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_DIV_H  = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_DIV_S  = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_sel    = rwct_pkg::DIV_SEL_HEIGHT;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == rwct_pkg::MODE_LOAD)
                    begin
                        cmd.capture_ray = 1'b1;
                        state_next      = S_LOAD;
                    end
                    else if (status.rows_pending)
                    begin
                        cmd.emit_row   = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_H;
            end
            S_DIV_H:
            begin
                if (status.div_done)
                begin
                    cmd.save_h = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = rwct_pkg::DIV_SEL_STEP;
                state_next    = S_DIV_S;
            end
            S_DIV_S:
            begin
                cmd.div_sel = rwct_pkg::DIV_SEL_STEP;
                if (status.div_done)
                begin
                    cmd.save_step = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/rwct_datapath.sv -----
`timescale 1ns / 1ps

// Texture size registers, ray arithmetic, column state and the output register.
module rwct_datapath #(
    parameter int SCREEN_ROWS = rwct_pkg::SCREEN_ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rwct_pkg::rwct_cmd_t             cmd,
    output rwct_pkg::rwct_status_t          status,
    input  logic                            cfg_we,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwct_pkg::SIZE_W-1:0]     cfg_data,
    input  logic [rwct_pkg::COL_W-1:0]      column,
    input  logic [rwct_pkg::DIST_W-1:0]     perp_distance,
    input  logic                            hit_vertical_side,
    input  logic                            step_x_negative,
    input  logic                            step_y_negative,
    input  logic signed [rwct_pkg::DIR_W-1:0] dir_x,
    input  logic signed [rwct_pkg::DIR_W-1:0] dir_y,
    input  logic [rwct_pkg::DIST_W-1:0]     player_x,
    input  logic [rwct_pkg::DIST_W-1:0]     player_y,
    output logic [rwct_pkg::COL_W-1:0]      out_column,
    output logic [rwct_pkg::ROW_W-1:0]      screen_row,
    output logic [1:0]                      texture_id,
    output logic [rwct_pkg::TEXEL_W-1:0]    texel_x,
    output logic [rwct_pkg::TEXEL_W-1:0]    texel_y,
    output logic                            last_row
);

    localparam int ROW_BITS   = $clog2(SCREEN_ROWS + 1);
    localparam int H_NUM_W    = ROW_BITS + 16;
    localparam int DIV_NUM_W  = (H_NUM_W > rwct_pkg::STEP_W) ? H_NUM_W : rwct_pkg::STEP_W;
    localparam int HALF_ROWS  = SCREEN_ROWS / 2;
    localparam int END_GAP    = SCREEN_ROWS - 1 - HALF_ROWS;
    localparam int NUMV_W     = rwct_pkg::DIST_W + 3;
    localparam int SIZE_W     = rwct_pkg::SIZE_W;
    localparam int DIST_W     = rwct_pkg::DIST_W;
    localparam int ROW_W      = rwct_pkg::ROW_W;
    localparam int STEP_W     = rwct_pkg::STEP_W;
    localparam int POS_W      = rwct_pkg::POS_W;

    // Texture size registers.
    logic [SIZE_W-1:0] north_width_reg, north_height_reg;
    logic [SIZE_W-1:0] south_width_reg, south_height_reg;
    logic [SIZE_W-1:0] west_width_reg,  west_height_reg;
    logic [SIZE_W-1:0] east_width_reg,  east_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            north_width_reg  <= rwct_pkg::SIZE_RESET;
            north_height_reg <= rwct_pkg::SIZE_RESET;
            south_width_reg  <= rwct_pkg::SIZE_RESET;
            south_height_reg <= rwct_pkg::SIZE_RESET;
            west_width_reg   <= rwct_pkg::SIZE_RESET;
            west_height_reg  <= rwct_pkg::SIZE_RESET;
            east_width_reg   <= rwct_pkg::SIZE_RESET;
            east_height_reg  <= rwct_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwct_pkg::CFG_NORTH_WIDTH:  north_width_reg  <= cfg_data;
                rwct_pkg::CFG_NORTH_HEIGHT: north_height_reg <= cfg_data;
                rwct_pkg::CFG_SOUTH_WIDTH:  south_width_reg  <= cfg_data;
                rwct_pkg::CFG_SOUTH_HEIGHT: south_height_reg <= cfg_data;
                rwct_pkg::CFG_WEST_WIDTH:   west_width_reg   <= cfg_data;
                rwct_pkg::CFG_WEST_HEIGHT:  west_height_reg  <= cfg_data;
                rwct_pkg::CFG_EAST_WIDTH:   east_width_reg   <= cfg_data;
                rwct_pkg::CFG_EAST_HEIGHT:  east_height_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Captured ray.
    logic [rwct_pkg::COL_W-1:0]        col_in_reg;
    logic [DIST_W-1:0]                 raw_reg;
    logic                              side_reg, sxn_reg, syn_reg;
    logic signed [rwct_pkg::DIR_W-1:0] dx_reg, dy_reg;
    logic [DIST_W-1:0]                 px_reg, py_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture_ray)
        begin
            col_in_reg <= column;
            raw_reg    <= perp_distance;
            side_reg   <= hit_vertical_side;
            sxn_reg    <= step_x_negative;
            syn_reg    <= step_y_negative;
            dx_reg     <= dir_x;
            dy_reg     <= dir_y;
            px_reg     <= player_x;
            py_reg     <= player_y;
        end
    end

    logic [1:0]        tid;
    logic [SIZE_W-1:0] w_load, ht_load;

    always_comb
    begin
        if (side_reg)
        begin
            tid = syn_reg ? rwct_pkg::TEX_NORTH : rwct_pkg::TEX_SOUTH;
        end
        else
        begin
            tid = sxn_reg ? rwct_pkg::TEX_WEST : rwct_pkg::TEX_EAST;
        end
    end

    assign w_load  = rwct_pkg::clamp_size(rwct_pkg::pick_size(tid,
                         north_width_reg, south_width_reg, west_width_reg, east_width_reg));
    assign ht_load = rwct_pkg::clamp_size(rwct_pkg::pick_size(tid,
                         north_height_reg, south_height_reg, west_height_reg, east_height_reg));

    // Wall hit fraction: three free-running stages fed from the captured ray.
    logic signed [rwct_pkg::DIR_W-1:0] dir_sel;
    logic [DIST_W-1:0]                 pos_sel;
    logic signed [DIST_W+rwct_pkg::DIR_W:0] hit_mul_reg;
    logic [29:0]                       hit_sum;
    logic [15:0]                       frac_reg;
    logic [SIZE_W+15:0]                frac_w_reg;
    logic [SIZE_W-1:0]                 tx, tx_mirror;
    logic                              mirror;

    assign dir_sel = side_reg ? dx_reg : dy_reg;
    assign pos_sel = side_reg ? px_reg : py_reg;
    assign hit_sum = hit_mul_reg[29:0] + {pos_sel[15:0], 14'b0};

    always_ff @(posedge clk)
    begin
        hit_mul_reg <= $signed({1'b0, raw_reg}) * dir_sel;
        frac_reg    <= hit_sum[29:14];
        frac_w_reg  <= frac_reg * w_load;
    end

    assign tx        = frac_w_reg[SIZE_W+15:16];
    assign tx_mirror = w_load - tx - SIZE_W'(1);
    assign mirror    = (!side_reg && !dx_reg[rwct_pkg::DIR_W-1] && (dx_reg != '0))
                    || (side_reg && dy_reg[rwct_pkg::DIR_W-1]);

    // Shared divider for slice height and texel step.
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DIST_W-1:0]    div_den, dist_clamped;
    logic                 div_done;
    logic [DIST_W-1:0]    h_reg;
    logic [STEP_W-1:0]    step_reg;

    assign dist_clamped = (raw_reg < rwct_pkg::MIN_DIST) ? rwct_pkg::MIN_DIST : raw_reg;

    always_comb
    begin
        if (cmd.div_sel == rwct_pkg::DIV_SEL_STEP)
        begin
            div_num = DIV_NUM_W'({ht_load, 16'b0});
            div_den = h_reg;
        end
        else
        begin
            div_num = DIV_NUM_W'(SCREEN_ROWS) << 16;
            div_den = dist_clamped;
        end
    end

    rwct_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIST_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.save_h)
        begin
            h_reg <= (div_q > DIV_NUM_W'(rwct_pkg::SLICE_MAX)) ? rwct_pkg::SLICE_MAX
                                                               : div_q[DIST_W-1:0];
        end
        if (cmd.save_step)
        begin
            step_reg <= (h_reg == '0) ? '0 : div_q[STEP_W-1:0];
        end
    end

    // Slice limits and starting texel position.
    logic [DIST_W-2:0]        h_half;
    logic [ROW_W-1:0]         start_row, stop_row;
    logic signed [NUMV_W-1:0] pos_num;
    logic signed [NUMV_W+STEP_W:0] pos_prod_reg;

    assign h_half    = h_reg[DIST_W-1:1];
    assign start_row = (h_half >= (DIST_W-1)'(HALF_ROWS)) ? '0
                     : ROW_W'((DIST_W-1)'(HALF_ROWS) - h_half);
    assign stop_row  = (h_half >= (DIST_W-1)'(END_GAP)) ? ROW_W'(SCREEN_ROWS - 1)
                     : ROW_W'((DIST_W-1)'(HALF_ROWS) + h_half);
    assign pos_num   = $signed({{(NUMV_W-ROW_W-1){1'b0}}, start_row, 1'b0})
                     - $signed(NUMV_W'(SCREEN_ROWS))
                     + $signed({{(NUMV_W-DIST_W){1'b0}}, h_reg});

    always_ff @(posedge clk)
    begin
        pos_prod_reg <= pos_num * $signed({1'b0, step_reg});
    end

    // Column state.
    logic [rwct_pkg::COL_W-1:0]   active_column_reg;
    logic [1:0]                   current_texture_reg;
    logic [rwct_pkg::TEXEL_W-1:0] texture_column_reg;
    logic [ROW_W-1:0]             next_row_reg, end_row_reg;
    logic [POS_W-1:0]             texel_position_reg, texel_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_column_reg   <= '0;
            current_texture_reg <= '0;
            texture_column_reg  <= '0;
            next_row_reg        <= '0;
            end_row_reg         <= '0;
            texel_position_reg  <= '0;
            texel_step_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            active_column_reg   <= col_in_reg;
            current_texture_reg <= tid;
            texture_column_reg  <= mirror ? tx_mirror[rwct_pkg::TEXEL_W-1:0]
                                          : tx[rwct_pkg::TEXEL_W-1:0];
            next_row_reg        <= start_row;
            end_row_reg         <= stop_row;
            texel_position_reg  <= pos_prod_reg[POS_W:1];
            texel_step_reg      <= POS_W'(step_reg);
        end
        else if (cmd.emit_row)
        begin
            texel_position_reg <= texel_position_reg + texel_step_reg;
            next_row_reg       <= next_row_reg + ROW_W'(1);
        end
    end

    // Texel row, clamped against the live height of the current texture.
    logic [SIZE_W-1:0] ht_live, ty;
    logic [15:0]       ty_raw;

    assign ht_live = rwct_pkg::clamp_size(rwct_pkg::pick_size(current_texture_reg,
                         north_height_reg, south_height_reg, west_height_reg, east_height_reg));
    assign ty_raw  = texel_position_reg[POS_W-1] ? 16'd0 : texel_position_reg[POS_W-1:16];
    assign ty      = (ty_raw >= 16'(ht_live)) ? ht_live - SIZE_W'(1) : ty_raw[SIZE_W-1:0];

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_row)
        begin
            out_column <= active_column_reg;
            screen_row <= next_row_reg;
            texture_id <= current_texture_reg;
            texel_x    <= texture_column_reg;
            texel_y    <= ty[rwct_pkg::TEXEL_W-1:0];
            last_row   <= (next_row_reg + ROW_W'(1)) == end_row_reg;
        end
    end

    assign status.div_done     = div_done;
    assign status.rows_pending = next_row_reg < end_row_reg;

endmodule

// ----- sv/raycast_wall_column_texturer.sv -----
`timescale 1ns / 1ps

// Textured wall column stepper for a grid raycaster. A mode 0 item loads one ray hit for a
// screen column; the block then works out the slice height, the first and last rows, the wall
// texture, the mirrored texture column and the per-row texture step. Each mode 1 item that
// follows gives one pixel request and advances the texture position; once the column's rows are
// used up a mode 1 item gives nothing. Row ticks are taken every cycle while results are drained.
// No item is taken while a ray load runs. The shared one-bit-per-cycle divider, whose quotient
// is max(clog2(SCREEN_ROWS+1) + 16, 27) bits wide (27 at the default of 512 rows), makes one
// pass for the slice height and then one for the texture step.
// Texture sizes may be written only while no ray load is under way.
module raycast_wall_column_texturer #(
    parameter int SCREEN_ROWS = rwct_pkg::SCREEN_ROWS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rwct_pkg::SIZE_W-1:0]       cfg_data,
    // Input items.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [rwct_pkg::COL_W-1:0]        column,
    input  logic [rwct_pkg::DIST_W-1:0]       perp_distance,
    input  logic                              hit_vertical_side,
    input  logic                              step_x_negative,
    input  logic                              step_y_negative,
    input  logic signed [rwct_pkg::DIR_W-1:0] dir_x,
    input  logic signed [rwct_pkg::DIR_W-1:0] dir_y,
    input  logic [rwct_pkg::DIST_W-1:0]       player_x,
    input  logic [rwct_pkg::DIST_W-1:0]       player_y,
    // Result items.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rwct_pkg::COL_W-1:0]        out_column,
    output logic [rwct_pkg::ROW_W-1:0]        screen_row,
    output logic [1:0]                        texture_id,
    output logic [rwct_pkg::TEXEL_W-1:0]      texel_x,
    output logic [rwct_pkg::TEXEL_W-1:0]      texel_y,
    output logic                              last_row
);

    rwct_pkg::rwct_cmd_t    cmd;
    rwct_pkg::rwct_status_t status;

    // The controller sequences the load and owns both handshakes; a pixel that waits in
    // the datapath's output register lets a new tick in only as the receiver takes it.
    rwct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // The datapath holds texture sizes, the captured ray, the divider, the
    // multipliers and the column state that row ticks step through.
    rwct_datapath #(
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .column            (column),
        .perp_distance     (perp_distance),
        .hit_vertical_side (hit_vertical_side),
        .step_x_negative   (step_x_negative),
        .step_y_negative   (step_y_negative),
        .dir_x             (dir_x),
        .dir_y             (dir_y),
        .player_x          (player_x),
        .player_y          (player_y),
        .out_column        (out_column),
        .screen_row        (screen_row),
        .texture_id        (texture_id),
        .texel_x           (texel_x),
        .texel_y           (texel_y),
        .last_row          (last_row)
    );

    // A ray load holds off further items while its arithmetic runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == rwct_pkg::MODE_LOAD)) |=> !in_ready)
        else $error("input taken straight after a ray load");

    // A row tick with rows left must leave a pixel in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == rwct_pkg::MODE_ROW) && status.rows_pending)
        |=> out_valid)
        else $error("row tick with rows pending produced no pixel");

    // The divider only finishes while a load is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> !in_ready)
        else $error("divider finished while the block was taking items");

endmodule

// ----- tb/tb_raycast_wall_column_texturer.sv -----
`timescale 1ns / 1ps

module tb_raycast_wall_column_texturer;

    import rwct_pkg::*;

    // Run shape. The settling pause before any texture size write is long enough for a ray load
    // that is still running to finish first.
    localparam int ROWS          = SCREEN_ROWS_DEFAULT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_PHASES    = 6;

    // Register i of the texture size bank sits at index i.
    localparam logic [CFG_IDX_W-1:0] SIZE_REG_INDEX [8] = '{
        CFG_NORTH_WIDTH, CFG_NORTH_HEIGHT, CFG_SOUTH_WIDTH, CFG_SOUTH_HEIGHT,
        CFG_WEST_WIDTH,  CFG_WEST_HEIGHT,  CFG_EAST_WIDTH,  CFG_EAST_HEIGHT
    };

    // One input item as it crosses the input handshake.
    typedef struct packed {
        logic                mode;
        logic [COL_W-1:0]    column;
        logic [DIST_W-1:0]   perp_distance;
        logic                vertical_side;
        logic                step_x_neg;
        logic                step_y_neg;
        logic [DIR_W-1:0]    dir_x;
        logic [DIR_W-1:0]    dir_y;
        logic [DIST_W-1:0]   player_x;
        logic [DIST_W-1:0]   player_y;
    } ray_item_t;

    // One pixel request as it leaves the block.
    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [1:0]         texture;
        logic [TEXEL_W-1:0] tx;
        logic [TEXEL_W-1:0] ty;
        logic               last;
    } pixel_t;

    // How an accepted item is to be checked: either against the column stepper model, or
    // against a pixel (or the absence of one) typed straight into the directed table.
    typedef struct {
        bit     fixed;
        bit     has_pixel;
        pixel_t pixel;
    } pixel_plan_t;

    typedef struct {
        ray_item_t item;
        bit        fixed;
        bit        has_pixel;
        pixel_t    pixel;
    } directed_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [SIZE_W-1:0]         cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      mode;
    logic [COL_W-1:0]          column;
    logic [DIST_W-1:0]         perp_distance;
    logic                      hit_vertical_side;
    logic                      step_x_negative;
    logic                      step_y_negative;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic [DIST_W-1:0]         player_x;
    logic [DIST_W-1:0]         player_y;
    logic                      out_valid;
    logic                      out_ready;
    logic [COL_W-1:0]          out_column;
    logic [ROW_W-1:0]          screen_row;
    logic [1:0]                texture_id;
    logic [TEXEL_W-1:0]        texel_x;
    logic [TEXEL_W-1:0]        texel_y;
    logic                      last_row;

    raycast_wall_column_texturer #(
        .SCREEN_ROWS(ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .column(column),
        .perp_distance(perp_distance),
        .hit_vertical_side(hit_vertical_side),
        .step_x_negative(step_x_negative),
        .step_y_negative(step_y_negative),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .player_x(player_x),
        .player_y(player_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_column(out_column),
        .screen_row(screen_row),
        .texture_id(texture_id),
        .texel_x(texel_x),
        .texel_y(texel_y),
        .last_row(last_row)
    );

    // Model state of the column stepper, kept apart from the block's own.
    logic [SIZE_W-1:0]  size_reg [8];
    logic [COL_W-1:0]   col_active;
    logic [1:0]         tex_active;
    logic [TEXEL_W-1:0] tex_column;
    int unsigned        row_next;
    int unsigned        row_end;
    logic [31:0]        tex_pos;
    logic [31:0]        model_step;

    // Pixels still owed by the block, oldest first, and the check plan of every item offered.
    pixel_t      pixel_queue [$];
    pixel_plan_t plan_queue [$];
    directed_row_t directed_rows [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int counted_items = 0;
    int send_idle_pct = 35;
    int recv_idle_pct = 75;
    bit hold_receiver = 1'b0;

    ray_item_t   seen_item;
    pixel_plan_t seen_plan;
    bit          seen_emits;
    pixel_t      seen_pixel;
    pixel_t      wanted;

    // The clock runs with a 10 ns period from the first instant.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want, input int row);
        if (got != want)
        begin
            report_mismatch($sformatf("row %0d %s: got %0d, expected %0d", row, name, got, want));
        end
    endtask

    // Texture sizes outside 1..1024 are pulled back into range before use.
    function automatic int unsigned texels_in_range(input logic [SIZE_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > SIZE_MAX)
        begin
            return SIZE_MAX;
        end
        return v;
    endfunction

    // Column stepper model. A ray load works out the slice, texture, mirrored texture column,
    // texture step and starting texture position, and gives nothing. A row tick gives one pixel
    // while rows remain, then moves the texture position on by one step.
    task automatic texture_column_step(input ray_item_t it, output bit emits, output pixel_t px);
        logic [63:0] clamped_dist;
        logic [63:0] slice;
        logic [63:0] dir64;
        logic [63:0] hit;
        logic [63:0] frac;
        logic [63:0] texel;
        logic [63:0] width;
        logic [63:0] height;
        longint      first_row;
        longint      end_limit;
        longint      offset;
        longint      scaled;
        logic [1:0]  tid;

        emits = 1'b0;
        px    = '0;
        if (it.mode == MODE_LOAD)
        begin
            // Distances below the minimum are raised to it; the slice height saturates.
            clamped_dist = (it.perp_distance < MIN_DIST) ? 64'(MIN_DIST)
                                                         : 64'(it.perp_distance);
            slice = (64'(ROWS) << 16) / clamped_dist;
            if (slice > 64'(SLICE_MAX))
            begin
                slice = 64'(SLICE_MAX);
            end
            first_row = longint'(ROWS / 2) - longint'(slice / 2);
            end_limit = longint'(ROWS / 2) + longint'(slice / 2);
            if (first_row < 0)
            begin
                first_row = 0;
            end
            if (end_limit >= ROWS)
            begin
                end_limit = ROWS - 1;
            end

            if (it.vertical_side)
            begin
                tid = it.step_y_neg ? TEX_NORTH : TEX_SOUTH;
            end
            else
            begin
                tid = it.step_x_neg ? TEX_WEST : TEX_EAST;
            end
            width  = 64'(texels_in_range(size_reg[{tid, 1'b0}]));
            height = 64'(texels_in_range(size_reg[{tid, 1'b1}]));

            // The wall hit uses the raw distance; only its fraction picks the texture column.
            if (it.vertical_side)
            begin
                dir64 = {{(64 - DIR_W){it.dir_x[DIR_W-1]}}, it.dir_x};
                hit   = 64'(it.perp_distance) * dir64 + (64'(it.player_x) << 14);
            end
            else
            begin
                dir64 = {{(64 - DIR_W){it.dir_y[DIR_W-1]}}, it.dir_y};
                hit   = 64'(it.perp_distance) * dir64 + (64'(it.player_y) << 14);
            end
            frac  = (hit >> 14) & 64'hFFFF;
            texel = (frac * width) >> 16;
            if ((!it.vertical_side && $signed(it.dir_x) > 0) ||
                (it.vertical_side && it.dir_y[DIR_W-1]))
            begin
                texel = width - texel - 1;
            end

            model_step = (slice == '0) ? 32'd0 : 32'((height << 16) / slice);
            offset     = 2 * first_row - ROWS + longint'(slice);
            scaled     = offset * longint'({32'd0, model_step});
            // Halving rounds towards minus infinity, as an arithmetic shift does.
            tex_pos    = 32'(scaled >>> 1);

            col_active = it.column;
            tex_active = tid;
            tex_column = TEXEL_W'(texel);
            row_next   = int'(first_row);
            row_end    = int'(end_limit);
        end
        else if (row_next < row_end)
        begin
            // The height in force now is used for the clamp, even if it changed mid-column.
            height = 64'(texels_in_range(size_reg[{tex_active, 1'b1}]));
            texel  = tex_pos[31] ? 64'd0 : 64'(tex_pos[31:16]);
            if (texel >= height)
            begin
                texel = height - 1;
            end
            emits      = 1'b1;
            px.column  = col_active;
            px.row     = ROW_W'(row_next);
            px.texture = tex_active;
            px.tx      = tex_column;
            px.ty      = TEXEL_W'(texel);
            px.last    = (row_next + 1 == row_end);
            tex_pos    = tex_pos + model_step;
            row_next   = row_next + 1;
        end
    endtask

    // Both handshakes are observed here at the rising edge. Texture size writes and accepted
    // input items update the model first; any result taken at the same edge is then checked
    // against the oldest pixel still owed.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_raycast_wall_column_texturer failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_we && cfg_index < 8)
            begin
                size_reg[cfg_index[2:0]] = cfg_data;
            end

            if (in_valid && in_ready)
            begin
                seen_item.mode          = mode;
                seen_item.column        = column;
                seen_item.perp_distance = perp_distance;
                seen_item.vertical_side = hit_vertical_side;
                seen_item.step_x_neg    = step_x_negative;
                seen_item.step_y_neg    = step_y_negative;
                seen_item.dir_x         = dir_x;
                seen_item.dir_y         = dir_y;
                seen_item.player_x      = player_x;
                seen_item.player_y      = player_y;
                seen_plan = plan_queue.pop_front();
                texture_column_step(seen_item, seen_emits, seen_pixel);
                counted_items++;
                if (seen_plan.fixed)
                begin
                    if (seen_plan.has_pixel)
                    begin
                        pixel_queue.push_back(seen_plan.pixel);
                    end
                end
                else if (seen_emits)
                begin
                    pixel_queue.push_back(seen_pixel);
                end
            end

            if (out_valid && out_ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    report_mismatch($sformatf("pixel at column %0d row %0d with nothing owed",
                                              out_column, screen_row));
                end
                else
                begin
                    wanted = pixel_queue.pop_front();
                    check_field("out_column", out_column, wanted.column, wanted.row);
                    check_field("screen_row", screen_row, wanted.row, wanted.row);
                    check_field("texture_id", texture_id, wanted.texture, wanted.row);
                    check_field("texel_x", texel_x, wanted.tx, wanted.row);
                    check_field("texel_y", texel_y, wanted.ty, wanted.row);
                    check_field("last_row", last_row, wanted.last, wanted.row);
                end
            end
        end
    end

    // The receiver changes its ready at the falling edge. When asked, it holds off for a long
    // stretch so that the block fills up and has to stall its input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_receiver = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one item from a falling edge and returns at the falling edge after it is taken.
    // Valid is only lowered during an idle gap, never in the step in which it is raised.
    task automatic offer_item(input ray_item_t it, input bit fixed, input bit has_pixel,
                              input pixel_t px);
        pixel_plan_t plan;

        plan.fixed     = fixed;
        plan.has_pixel = has_pixel;
        plan.pixel     = px;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        mode              <= it.mode;
        column            <= it.column;
        perp_distance     <= it.perp_distance;
        hit_vertical_side <= it.vertical_side;
        step_x_negative   <= it.step_x_neg;
        step_y_negative   <= it.step_y_neg;
        dir_x             <= it.dir_x;
        dir_y             <= it.dir_y;
        player_x          <= it.player_x;
        player_y          <= it.player_y;
        in_valid          <= 1'b1;
        plan_queue.push_back(plan);
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Waits until every owed pixel has come out, then lets a possible ray load run to its end.
    task automatic drain_results();
        int waited;

        waited = 0;
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pixel_queue.size() != 0)
        begin
            report_mismatch($sformatf("%0d pixels never came out", pixel_queue.size()));
            pixel_queue.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Size settings per phase: the smallest, the largest, out-of-range values, then random ones.
    function automatic logic [SIZE_W-1:0] size_for_phase(input int phase, input int i);
        case (phase)
            0: return SIZE_MIN;
            1: return SIZE_MAX;
            2:
            begin
                case (i % 4)
                    0: return 11'd0;
                    1: return 11'd2047;
                    2: return 11'd1025;
                    default: return SIZE_W'($urandom_range(1, 1024));
                endcase
            end
            5: return SIZE_W'($urandom_range(0, 2047));
            default: return SIZE_W'($urandom_range(1, 1024));
        endcase
    endfunction

    task automatic program_texture_sizes(input int phase);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= SIZE_REG_INDEX[i];
            cfg_data  <= size_for_phase(phase, i);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DIR_W-1:0] random_direction();
        case ($urandom_range(15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0001;
            4: return 16'hFFFF;
            default: return DIR_W'($urandom());
        endcase
    endfunction

    // A row tick carries random values in the fields that only a load reads.
    function automatic ray_item_t random_tick();
        ray_item_t it;

        it.mode          = MODE_ROW;
        it.column        = COL_W'($urandom());
        it.perp_distance = DIST_W'($urandom());
        it.vertical_side = 1'($urandom());
        it.step_x_neg    = 1'($urandom());
        it.step_y_neg    = 1'($urandom());
        it.dir_x         = DIR_W'($urandom());
        it.dir_y         = DIR_W'($urandom());
        it.player_x      = DIST_W'($urandom());
        it.player_y      = DIST_W'($urandom());
        return it;
    endfunction

    // Most loads are far enough away to give short columns; some are very near, some clamp.
    function automatic ray_item_t random_load();
        ray_item_t it;
        int        r;

        it      = random_tick();
        it.mode = MODE_LOAD;
        r = $urandom_range(99);
        if (r < 50)
        begin
            it.perp_distance = DIST_W'($urandom_range(24'h080000, 24'hFFFFFF));
        end
        else if (r < 70)
        begin
            it.perp_distance = DIST_W'($urandom_range(24'h010000, 24'h080000));
        end
        else if (r < 80)
        begin
            it.perp_distance = DIST_W'($urandom_range(0, 15));
        end
        it.dir_x = random_direction();
        it.dir_y = random_direction();
        return it;
    endfunction

    function automatic ray_item_t ray_load(input int col, input int distance, input bit side,
                                           input bit sxn, input bit syn, input int dx,
                                           input int dy, input int px, input int py);
        ray_item_t it;

        it.mode          = MODE_LOAD;
        it.column        = COL_W'(col);
        it.perp_distance = DIST_W'(distance);
        it.vertical_side = side;
        it.step_x_neg    = sxn;
        it.step_y_neg    = syn;
        it.dir_x         = DIR_W'(dx);
        it.dir_y         = DIR_W'(dy);
        it.player_x      = DIST_W'(px);
        it.player_y      = DIST_W'(py);
        return it;
    endfunction

    function automatic pixel_t pixel_of(input int col, input int row, input logic [1:0] tex,
                                        input int tx, input int ty, input bit last);
        pixel_t px;

        px.column  = COL_W'(col);
        px.row     = ROW_W'(row);
        px.texture = tex;
        px.tx      = TEXEL_W'(tx);
        px.ty      = TEXEL_W'(ty);
        px.last    = last;
        return px;
    endfunction

    task automatic add_row(input ray_item_t it, input bit fixed, input bit has_pixel,
                           input pixel_t px);
        directed_row_t row;

        row.item      = it;
        row.fixed     = fixed;
        row.has_pixel = has_pixel;
        row.pixel     = px;
        directed_rows.push_back(row);
    endtask

    // Well-formed columns with random content make up most of a phase; the rest are loads
    // that are overtaken at once and stray row ticks with nothing left to draw.
    task automatic run_random_phase(input int phase);
        int        goal;
        int        n;
        int        r;
        ray_item_t it;

        goal = counted_items + PHASE_ITEMS;
        // A few row ticks first, so that the sizes just written land in the middle of a column.
        n = $urandom_range(1, 8);
        repeat (n) offer_item(random_tick(), 1'b0, 1'b0, '0);
        if (phase == 4)
        begin
            // One full-height column, drained to the end and beyond.
            it = random_load();
            it.perp_distance = 24'h010000;
            offer_item(it, 1'b0, 1'b0, '0);
            repeat (ROWS + 4) offer_item(random_tick(), 1'b0, 1'b0, '0);
        end
        while (counted_items < goal)
        begin
            r = $urandom_range(99);
            if (r < 85)
            begin
                offer_item(random_load(), 1'b0, 1'b0, '0);
                n = (r < 60) ? $urandom_range(0, 70) : $urandom_range(0, 6);
            end
            else if (r < 93)
            begin
                offer_item(random_load(), 1'b0, 1'b0, '0);
                offer_item(random_load(), 1'b0, 1'b0, '0);
                n = $urandom_range(1, 20);
            end
            else
            begin
                n = $urandom_range(1, 10);
            end
            repeat (n) offer_item(random_tick(), 1'b0, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        // Every input is known from the first instant, with reset held.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_valid          = 1'b0;
        mode              = MODE_ROW;
        column            = '0;
        perp_distance     = '0;
        hit_vertical_side = 1'b0;
        step_x_negative   = 1'b0;
        step_y_negative   = 1'b0;
        dir_x             = '0;
        dir_y             = '0;
        player_x          = '0;
        player_y          = '0;

        for (int i = 0; i < 8; i++)
        begin
            size_reg[i] = SIZE_RESET;
        end
        col_active = '0;
        tex_active = '0;
        tex_column = '0;
        row_next   = 0;
        row_end    = 0;
        tex_pos    = '0;
        model_step = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the reset sizes of 64. Pixels that can be read off by hand are
        // typed in; the rest go through the model.
        // Straight after reset nothing is pending, so a row tick gives nothing.
        add_row(random_tick(), 1'b1, 1'b0, '0);
        // Farthest wall: the slice is two rows high, rows 255 and 256, with a step of 32 texels.
        add_row(ray_load(4095, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0), 1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b1, 1'b1, pixel_of(4095, 255, TEX_EAST, 0, 0, 1'b0));
        add_row(random_tick(), 1'b1, 1'b1, pixel_of(4095, 256, TEX_EAST, 0, 32, 1'b1));
        // With the column used up, a further tick gives nothing.
        add_row(random_tick(), 1'b1, 1'b0, '0);
        // Zero distance is raised to the minimum; the slice covers the screen and the texture
        // step rounds down to zero, so the top rows all read texel row 0.
        add_row(ray_load(0, 0, 1'b1, 1'b0, 1'b1, 0, 0, 0, 0), 1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b1, 1'b1, pixel_of(0, 0, TEX_NORTH, 0, 0, 1'b0));
        add_row(random_tick(), 1'b1, 1'b1, pixel_of(0, 1, TEX_NORTH, 0, 0, 1'b0));
        add_row(random_tick(), 1'b0, 1'b0, '0);
        // A load while rows are pending replaces them: distance just under the minimum,
        // south face, extreme directions and positions, mirrored by a negative y direction.
        add_row(ray_load(1234, 6, 1'b1, 1'b1, 1'b0, 32767, -32768, 24'hFFFFFF, 24'hFFFFFF),
                1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b0, 1'b0, '0);
        // Exactly the minimum distance on a west face, mirrored by a positive x direction.
        add_row(ray_load(2048, 7, 1'b0, 1'b1, 1'b1, 32767, -32768, 0, 24'h123456),
                1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b0, 1'b0, '0);
        // Unit distance on an east face: the slice is exactly the screen height.
        add_row(ray_load(7, 24'h010000, 1'b0, 1'b0, 1'b0, -32768, 32767, 24'hFFFFFF,
                         24'hFFFFFF), 1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b0, 1'b0, '0);
        // Two units away on a north face: a half-height slice, mirrored.
        add_row(ray_load(300, 24'h020000, 1'b1, 1'b0, 1'b1, -1, -1, 24'h00ABCD, 0),
                1'b0, 1'b0, '0);
        add_row(random_tick(), 1'b0, 1'b0, '0);
        // A short slice on a south face, run past its end.
        add_row(ray_load(4000, 24'h7FFFFF, 1'b1, 1'b0, 1'b0, 1, 1, 24'h345678, 24'h876543),
                1'b0, 1'b0, '0);
        repeat (5) add_row(random_tick(), 1'b0, 1'b0, '0);

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].item, directed_rows[i].fixed,
                       directed_rows[i].has_pixel, directed_rows[i].pixel);
        end
        drain_results();

        // Random part. The sender idles with a chance of 35 in a hundred and the receiver of 75 for
        // the first two phases, the other way round for the next two, and neither for the last two.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 75;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_texture_sizes(phase);
            if (phase == 1)
            begin
                hold_receiver = 1'b1;
            end
            run_random_phase(phase);
            drain_results();
        end

        if (error_count == 0)
        begin
            $display("tb_raycast_wall_column_texturer passed");
        end
        else
        begin
            $display("tb_raycast_wall_column_texturer failed");
        end
        $finish;
    end

endmodule
